@@ rtl/core/dtpc_pkg.sv @@
// Package for the distance threshold point clustering unit.
// Holds sizes, word structs and the sequencer state type; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dtpc_pkg;
	localparam int MAX_POINTS = 64;
	localparam int COORD_BITS = 16;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int CRIT_W     = 34;
	localparam int SQ_W       = 2 * COORD_BITS;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] pos_x;
		logic signed [COORD_BITS-1:0] pos_y;
		logic signed [COORD_BITS-1:0] pos_z;
		logic                         is_proton;
		logic                         is_spectator;
		logic                         side;
		logic                         last;
	} in_word_t;

	typedef struct packed {
		logic                         out_side;
		logic [5:0]                   cluster_number;
		logic signed [COORD_BITS-1:0] member_x;
		logic signed [COORD_BITS-1:0] member_y;
		logic signed [COORD_BITS-1:0] member_z;
		logic                         member_proton;
		logic [6:0]                   cluster_mass;
		logic [6:0]                   cluster_charge;
		logic                         last_of_cluster;
		logic                         last_of_event;
	} out_word_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic signed [COORD_BITS-1:0] z;
		logic                         proton;
		logic                         side;
	} point_t;

	typedef enum logic [4:0] {
		S_LOAD, S_INIT, S_PI_RD, S_PI_LAT, S_PJ_RD, S_PJ_LAT, S_W1, S_W2, S_CHK,
		S_FI_RD, S_FI_CHK, S_FJ_RD, S_FJ_CHK, S_RT_A, S_RT_B, S_RT_C,
		S_EL_RD, S_EL_CHK, S_CN_RD, S_CN_CHK, S_EM_RD, S_EM_CHK, S_FLUSH
	} state_t;
endpackage
`default_nettype wire

@@ rtl/core/distance_threshold_point_clustering_unit.sv @@
// Top level: point and link memories, pair sequencer, cluster output; uses dtpc_pkg, dtpc_ram, dtpc_dist.
// Input words are taken one per cycle while loading; after the last, the links are initialised,
// each pair is checked, a pair that joins follows both links to their roots, roots are flattened,
// then per side the leaders are found and each leader's members are counted and output; output stalls hold this.
// Throughput: one event at a time; input stalls from the last word until the flush.
// Reset: arst_n clears control state and the threshold; memories hold no reset.
`timescale 1ns / 1ps
`default_nettype none
module distance_threshold_point_clustering_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire dtpc_pkg::in_word_t          in_word,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output dtpc_pkg::out_word_t              out_word,
	input  wire logic                        cfg_we,
	input  wire logic [dtpc_pkg::CRIT_W-1:0] cfg_wdata
);
	localparam int IW = dtpc_pkg::IDX_W;
	localparam int CW = dtpc_pkg::CNT_W;

	dtpc_pkg::state_t state_q, state_d;
	logic [dtpc_pkg::CRIT_W-1:0] crit_q;
	logic [CW-1:0] cnt_q, n_q, i_q, j_q, k_q;
	logic [IW-1:0] a_q, ri_q;
	logic          s_q;
	logic [5:0]    cnum_q;
	logic [CW-1:0] mass_q, charge_q, seen_q;
	dtpc_pkg::point_t pi_q;
	dtpc_pkg::out_word_t pend_q, out_q, new_w;
	logic pend_v_q, out_v_q;

	logic in_acc, keep, out_free, push;
	logic [CW-1:0] new_cnt;

	logic          pt_we;
	logic [IW-1:0] pt_raddr;
	dtpc_pkg::point_t pt_wdata, pt_rdata;
	logic          par_we;
	logic [IW-1:0] par_waddr, par_wdata, par_raddr, par_rdata;
	logic          close_s3;

	assign in_stall  = state_q != dtpc_pkg::S_LOAD;
	assign in_acc    = in_valid && !in_stall;
	assign keep      = in_word.is_spectator && (cnt_q < CW'(dtpc_pkg::MAX_POINTS));
	assign new_cnt   = cnt_q + CW'(keep);
	assign out_free  = !out_v_q || !out_stall;
	assign out_valid = out_v_q;
	assign out_word  = out_q;

	assign pt_we    = in_acc && keep;
	assign pt_wdata = '{x: in_word.pos_x, y: in_word.pos_y, z: in_word.pos_z,
	                    proton: in_word.is_proton, side: in_word.side};

	dtpc_ram #(.WIDTH($bits(dtpc_pkg::point_t)), .DEPTH(dtpc_pkg::MAX_POINTS)) u_pt_ram (
		.clk(clk), .we(pt_we), .waddr(cnt_q[IW-1:0]), .wdata(pt_wdata),
		.raddr(pt_raddr), .rdata(pt_rdata)
	);

	dtpc_ram #(.WIDTH(IW), .DEPTH(dtpc_pkg::MAX_POINTS)) u_par_ram (
		.clk(clk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
		.raddr(par_raddr), .rdata(par_rdata)
	);

	dtpc_dist u_dist (
		.clk(clk), .pt_a(pi_q), .pt_b(pt_rdata), .crit(crit_q), .close_s3(close_s3)
	);

	assign new_w = '{out_side: s_q, cluster_number: cnum_q, member_x: pt_rdata.x,
	                 member_y: pt_rdata.y, member_z: pt_rdata.z,
	                 member_proton: pt_rdata.proton, cluster_mass: 7'(mass_q),
	                 cluster_charge: 7'(charge_q),
	                 last_of_cluster: (seen_q + CW'(1)) == mass_q, last_of_event: 1'b0};

	always_comb begin
		state_d   = state_q;
		pt_raddr  = i_q[IW-1:0];
		par_raddr = i_q[IW-1:0];
		par_we    = 1'b0;
		par_waddr = k_q[IW-1:0];
		par_wdata = k_q[IW-1:0];
		push      = 1'b0;
		unique case (state_q)
			dtpc_pkg::S_LOAD: begin
				if (in_acc && in_word.last) state_d = dtpc_pkg::S_INIT;
			end
			dtpc_pkg::S_INIT: begin
				if (k_q < n_q) par_we = 1'b1;
				else state_d = dtpc_pkg::S_PI_RD;
			end
			dtpc_pkg::S_PI_RD: begin
				if (i_q >= n_q) state_d = dtpc_pkg::S_RT_A;
				else state_d = dtpc_pkg::S_PI_LAT;
			end
			dtpc_pkg::S_PI_LAT: state_d = dtpc_pkg::S_PJ_RD;
			dtpc_pkg::S_PJ_RD: begin
				pt_raddr = j_q[IW-1:0];
				if (j_q >= n_q) state_d = dtpc_pkg::S_PI_RD;
				else state_d = dtpc_pkg::S_PJ_LAT;
			end
			dtpc_pkg::S_PJ_LAT: begin
				pt_raddr = j_q[IW-1:0];
				state_d  = dtpc_pkg::S_W1;
			end
			dtpc_pkg::S_W1: state_d = dtpc_pkg::S_W2;
			dtpc_pkg::S_W2: state_d = dtpc_pkg::S_CHK;
			dtpc_pkg::S_CHK: begin
				state_d = close_s3 ? dtpc_pkg::S_FI_RD : dtpc_pkg::S_PJ_RD;
			end
			dtpc_pkg::S_FI_RD: begin
				par_raddr = a_q;
				state_d   = dtpc_pkg::S_FI_CHK;
			end
			dtpc_pkg::S_FI_CHK: begin
				par_raddr = a_q;
				state_d   = (par_rdata == a_q) ? dtpc_pkg::S_FJ_RD : dtpc_pkg::S_FI_RD;
			end
			dtpc_pkg::S_FJ_RD: begin
				par_raddr = a_q;
				state_d   = dtpc_pkg::S_FJ_CHK;
			end
			dtpc_pkg::S_FJ_CHK: begin
				par_raddr = a_q;
				if (par_rdata == a_q) begin
					state_d = dtpc_pkg::S_PJ_RD;
					if (ri_q < a_q) begin
						par_we = 1'b1; par_waddr = a_q; par_wdata = ri_q;
					end else if (a_q < ri_q) begin
						par_we = 1'b1; par_waddr = ri_q; par_wdata = a_q;
					end
				end else begin
					state_d = dtpc_pkg::S_FJ_RD;
				end
			end
			dtpc_pkg::S_RT_A: begin
				par_raddr = k_q[IW-1:0];
				state_d   = (k_q >= n_q) ? dtpc_pkg::S_EL_RD : dtpc_pkg::S_RT_B;
			end
			dtpc_pkg::S_RT_B: begin
				par_raddr = par_rdata;
				state_d   = dtpc_pkg::S_RT_C;
			end
			dtpc_pkg::S_RT_C: begin
				par_we    = 1'b1;
				par_wdata = par_rdata;
				state_d   = dtpc_pkg::S_RT_A;
			end
			dtpc_pkg::S_EL_RD: begin
				if (i_q >= n_q) begin
					if (s_q) state_d = dtpc_pkg::S_FLUSH;
				end else begin
					state_d = dtpc_pkg::S_EL_CHK;
				end
			end
			dtpc_pkg::S_EL_CHK: begin
				state_d = (pt_rdata.side == s_q && par_rdata == i_q[IW-1:0])
				        ? dtpc_pkg::S_CN_RD : dtpc_pkg::S_EL_RD;
			end
			dtpc_pkg::S_CN_RD: begin
				pt_raddr  = j_q[IW-1:0];
				par_raddr = j_q[IW-1:0];
				state_d   = (j_q >= n_q) ? dtpc_pkg::S_EM_RD : dtpc_pkg::S_CN_CHK;
			end
			dtpc_pkg::S_CN_CHK: begin
				pt_raddr  = j_q[IW-1:0];
				par_raddr = j_q[IW-1:0];
				state_d   = dtpc_pkg::S_CN_RD;
			end
			dtpc_pkg::S_EM_RD: begin
				pt_raddr  = j_q[IW-1:0];
				par_raddr = j_q[IW-1:0];
				state_d   = (j_q >= n_q) ? dtpc_pkg::S_EL_RD : dtpc_pkg::S_EM_CHK;
			end
			dtpc_pkg::S_EM_CHK: begin
				pt_raddr  = j_q[IW-1:0];
				par_raddr = j_q[IW-1:0];
				if (par_rdata != i_q[IW-1:0]) begin
					state_d = dtpc_pkg::S_EM_RD;
				end else if (out_free) begin
					push    = 1'b1;
					state_d = dtpc_pkg::S_EM_RD;
				end
			end
			dtpc_pkg::S_FLUSH: begin
				if (!pend_v_q || out_free) state_d = dtpc_pkg::S_LOAD;
			end
			default: state_d = dtpc_pkg::S_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= dtpc_pkg::S_LOAD;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crit_q   <= '0;
			cnt_q    <= '0;
			n_q      <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cfg_we) crit_q <= cfg_wdata;
			if (in_acc) begin
				cnt_q <= in_word.last ? '0 : new_cnt;
				if (in_word.last) n_q <= new_cnt;
			end
			if (push) begin
				pend_v_q <= 1'b1;
				out_v_q  <= pend_v_q || (out_v_q && out_stall);
			end else if (state_q == dtpc_pkg::S_FLUSH && pend_v_q && out_free) begin
				pend_v_q <= 1'b0;
				out_v_q  <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			pend_q <= new_w;
			if (pend_v_q) out_q <= pend_q;
		end else if (state_q == dtpc_pkg::S_FLUSH && pend_v_q && out_free) begin
			out_q <= '{out_side: pend_q.out_side, cluster_number: pend_q.cluster_number,
			           member_x: pend_q.member_x, member_y: pend_q.member_y,
			           member_z: pend_q.member_z, member_proton: pend_q.member_proton,
			           cluster_mass: pend_q.cluster_mass,
			           cluster_charge: pend_q.cluster_charge,
			           last_of_cluster: pend_q.last_of_cluster, last_of_event: 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0; j_q <= '0; k_q <= '0; a_q <= '0; ri_q <= '0; s_q <= 1'b0;
			cnum_q <= '0; mass_q <= '0; charge_q <= '0; seen_q <= '0;
		end else begin
			unique case (state_q)
				dtpc_pkg::S_LOAD: k_q <= '0;
				dtpc_pkg::S_INIT: begin
					k_q <= k_q + CW'(1);
					i_q <= '0;
				end
				dtpc_pkg::S_PI_RD: begin
					j_q <= i_q + CW'(1);
					k_q <= '0;
				end
				dtpc_pkg::S_PJ_RD: if (j_q >= n_q) i_q <= i_q + CW'(1);
				dtpc_pkg::S_CHK: begin
					a_q <= i_q[IW-1:0];
					if (!close_s3) j_q <= j_q + CW'(1);
				end
				dtpc_pkg::S_FI_CHK: begin
					if (par_rdata == a_q) begin
						ri_q <= a_q;
						a_q  <= j_q[IW-1:0];
					end else begin
						a_q <= par_rdata;
					end
				end
				dtpc_pkg::S_FJ_CHK: begin
					if (par_rdata == a_q) j_q <= j_q + CW'(1);
					else a_q <= par_rdata;
				end
				dtpc_pkg::S_RT_A: begin
					i_q <= '0; s_q <= 1'b0; cnum_q <= '0;
				end
				dtpc_pkg::S_RT_C: k_q <= k_q + CW'(1);
				dtpc_pkg::S_EL_RD: begin
					if (i_q >= n_q && !s_q) begin
						s_q <= 1'b1; i_q <= '0; cnum_q <= '0;
					end
				end
				dtpc_pkg::S_EL_CHK: begin
					mass_q <= '0; charge_q <= '0; j_q <= i_q;
					if (!(pt_rdata.side == s_q && par_rdata == i_q[IW-1:0]))
						i_q <= i_q + CW'(1);
				end
				dtpc_pkg::S_CN_RD: begin
					if (j_q >= n_q) begin
						j_q <= i_q; seen_q <= '0;
					end
				end
				dtpc_pkg::S_CN_CHK: begin
					if (par_rdata == i_q[IW-1:0]) begin
						mass_q   <= mass_q + CW'(1);
						charge_q <= charge_q + CW'(pt_rdata.proton);
					end
					j_q <= j_q + CW'(1);
				end
				dtpc_pkg::S_EM_RD: begin
					if (j_q >= n_q) begin
						cnum_q <= cnum_q + 6'd1; i_q <= i_q + CW'(1);
					end
				end
				dtpc_pkg::S_EM_CHK: begin
					if (par_rdata != i_q[IW-1:0]) j_q <= j_q + CW'(1);
					else if (out_free) begin
						j_q <= j_q + CW'(1); seen_q <= seen_q + CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == dtpc_pkg::S_PI_LAT) pi_q <= pt_rdata;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		par_we |-> par_wdata <= par_waddr)
		else $error("link points upward");
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(dtpc_pkg::MAX_POINTS))
		else $error("kept count beyond capacity");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dtpc_pkg::S_LOAD |-> !pend_v_q)
		else $error("pending word left after event");
endmodule
`default_nettype wire

@@ rtl/core/dtpc_ram.sv @@
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module dtpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ rtl/core/dtpc_dist.sv @@
// Three-stage squared distance and threshold compare for one point pair.
// Depends on dtpc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dtpc_dist (
	input  wire logic                        clk,
	input  wire dtpc_pkg::point_t            pt_a,
	input  wire dtpc_pkg::point_t            pt_b,
	input  wire logic [dtpc_pkg::CRIT_W-1:0] crit,
	output logic                             close_s3
);
	logic signed [dtpc_pkg::COORD_BITS:0] dx_s1, dy_s1, dz_s1;
	logic                                 same_s1, same_s2;
	logic [dtpc_pkg::SQ_W-1:0]            sx_s2, sy_s2, sz_s2;
	logic [dtpc_pkg::CRIT_W-1:0]          sum;
	logic signed [2*dtpc_pkg::COORD_BITS+1:0] px, py, pz;

	always_ff @(posedge clk) begin
		dx_s1   <= (dtpc_pkg::COORD_BITS+1)'(pt_a.x) - (dtpc_pkg::COORD_BITS+1)'(pt_b.x);
		dy_s1   <= (dtpc_pkg::COORD_BITS+1)'(pt_a.y) - (dtpc_pkg::COORD_BITS+1)'(pt_b.y);
		dz_s1   <= (dtpc_pkg::COORD_BITS+1)'(pt_a.z) - (dtpc_pkg::COORD_BITS+1)'(pt_b.z);
		same_s1 <= pt_a.side == pt_b.side;
	end

	assign px = dx_s1 * dx_s1;
	assign py = dy_s1 * dy_s1;
	assign pz = dz_s1 * dz_s1;

	always_ff @(posedge clk) begin
		sx_s2   <= px[dtpc_pkg::SQ_W-1:0];
		sy_s2   <= py[dtpc_pkg::SQ_W-1:0];
		sz_s2   <= pz[dtpc_pkg::SQ_W-1:0];
		same_s2 <= same_s1;
	end

	assign sum = dtpc_pkg::CRIT_W'(sx_s2) + dtpc_pkg::CRIT_W'(sy_s2)
	           + dtpc_pkg::CRIT_W'(sz_s2);

	always_ff @(posedge clk) begin
		close_s3 <= same_s2 && (sum < crit);
	end
endmodule
`default_nettype wire
